// ===== src/bqf_pkg.sv =====
// Shared types and constants for the multichannel biquad filter unit.
// No dependencies; every other source file imports this package.
package bqf_pkg;

  localparam int MAX_CHANNELS   = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_BITS      = 32;
  localparam int CH_BITS        = 3;
  localparam int CNT_BITS       = 4;
  localparam int CFG_IDX_BITS   = 3;
  localparam int HIST_AW        = $clog2(MAX_CHANNELS);

  // Product and exact five-term sum widths
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RES_W  = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    {{(COEF_BITS-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
  localparam logic [CNT_BITS-1:0] CHAN_RESET = CNT_BITS'(2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHANNELS = 3'd0,
    REG_B0       = 3'd1,
    REG_B1       = 3'd2,
    REG_B2       = 3'd3,
    REG_A1       = 3'd4,
    REG_A2       = 3'd5
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_word_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  typedef struct packed {
    coef_word_t b0;
    coef_word_t b1;
    coef_word_t b2;
    coef_word_t a1;
    coef_word_t a2;
  } coef_t;

  typedef struct packed {
    logic               shift;
    logic [HIST_AW-1:0] ch;
    sample_t            x_new;
    sample_t            y_new;
  } hist_wr_t;

endpackage

// ===== src/bqf_history.sv =====
// Per-channel filter history (x1, x2, y1, y2) held in flip-flops.
// Depends on bqf_pkg.
module bqf_history
  import bqf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [HIST_AW-1:0] rd_ch,
  input  hist_wr_t           wr,
  output hist_t              rd
);

  hist_t entry [MAX_CHANNELS];

  assign rd = entry[rd_ch];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        entry[i] <= '0;
      end
    end else if (wr.shift) begin
      // shift the delay line of one channel
      entry[wr.ch].x2 <= entry[wr.ch].x1;
      entry[wr.ch].x1 <= wr.x_new;
      entry[wr.ch].y2 <= entry[wr.ch].y1;
      entry[wr.ch].y1 <= wr.y_new;
    end
  end

endmodule

// ===== src/bqf_datapath.sv =====
// Five-term multiply-accumulate, round to nearest and saturate to sample width.
// Depends on bqf_pkg.
module bqf_datapath
  import bqf_pkg::*;
(
  input  sample_t x,
  input  hist_t   h,
  input  coef_t   coef,
  output sample_t y,
  output logic    clip
);

  logic signed [PROD_W-1:0]  p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic        [RES_W-1:0]   res;
  logic [RES_W-SAMPLE_BITS:0] res_hi;

  assign p_b0 = coef.b0 * x;
  assign p_b1 = coef.b1 * h.x1;
  assign p_b2 = coef.b2 * h.x2;
  assign p_a1 = coef.a1 * h.y1;
  assign p_a2 = coef.a2 * h.y2;

  assign acc     = p_b0 + p_b1 + p_b2 - p_a1 - p_a2;
  assign acc_rnd = acc + ROUND_HALF;
  // floor shift: drop the fraction bits
  assign res     = acc_rnd[ACC_W-1:COEF_FRAC_BITS];
  assign res_hi  = res[RES_W-1:SAMPLE_BITS-1];

  always_comb begin
    clip = 1'b0;
    y    = res[SAMPLE_BITS-1:0];
    if (!((&res_hi) || !(|res_hi))) begin
      clip = 1'b1;
      y    = res[RES_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

endmodule

// ===== src/multichannel_biquad_filter_unit.sv =====
// Top level of the multichannel direct form I biquad filter unit.
// Depends on bqf_pkg, bqf_history and bqf_datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  input    | in_valid / in_stall | sample_in, channel_in
//  result   | out_valid/out_stall | sample_out, channel_out, clipped
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A beat passes the input register, then the multiply-accumulate into the
//  result register. One beat per cycle sustained while out_stall is low; the
//  per-channel feedback closes inside that single pass. Reset (rst, synchronous)
//  restores the coefficient and channel-count registers and clears every
//  history. A stalled result holds; an empty input register still takes one
//  beat, and in_stall is high while both are full and the result is stalled.
module multichannel_biquad_filter_unit
  import bqf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input samples
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  sample_in,
  input  logic [CH_BITS-1:0]      channel_in,
  // filtered samples
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_BITS-1:0]  sample_out,
  output logic [CH_BITS-1:0]      channel_out,
  output logic                    clipped,
  // register writes; cfg_ready is always high
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data
);

  // Configuration registers; a channel-count write clears all histories
  logic [CNT_BITS-1:0] channels_in_use;
  coef_t               coef;
  logic                cfg_write;
  logic                hist_clear;

  // Input register
  logic                in_full;
  sample_t             in_sample;
  logic [CH_BITS-1:0]  in_ch;

  logic                take;
  logic                advance;
  logic                active;
  hist_t               hist_rd;
  hist_wr_t            hist_wr;
  sample_t             y_filt;
  logic                y_clip;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CHAN_RESET;
      coef.b0         <= COEF_ONE;
      coef.b1         <= '0;
      coef.b2         <= '0;
      coef.a1         <= '0;
      coef.a2         <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNELS: channels_in_use <= cfg_data[CNT_BITS-1:0];
        REG_B0:       coef.b0 <= cfg_data;
        REG_B1:       coef.b1 <= cfg_data;
        REG_B2:       coef.b2 <= cfg_data;
        REG_A1:       coef.a1 <= cfg_data;
        REG_A2:       coef.a2 <= cfg_data;
        default: ;    // drop writes beyond the register list
      endcase
    end
  end

  assign hist_clear = cfg_write && (cfg_index == REG_CHANNELS);

  // Move the held beat forward whenever the result register is free or draining
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_sample <= sample_in;
      in_ch     <= channel_in;
    end
  end

  // A channel filters only when below both the programmed count and the
  // number of history slots; otherwise the sample passes through untouched.
  assign active = (CNT_BITS'(in_ch) < channels_in_use) &&
                  (int'(in_ch) < MAX_CHANNELS);

  bqf_history u_history (
    .clk   (clk),
    .rst   (rst),
    .clear (hist_clear),
    .rd_ch (in_ch[HIST_AW-1:0]),
    .wr    (hist_wr),
    .rd    (hist_rd)
  );

  bqf_datapath u_datapath (
    .x    (in_sample),
    .h    (hist_rd),
    .coef (coef),
    .y    (y_filt),
    .clip (y_clip)
  );

  // Advance the channel's delay line in the same cycle the result is captured,
  // so a following beat on the same channel sees the new history.
  assign hist_wr.shift = advance && active;
  assign hist_wr.ch    = in_ch[HIST_AW-1:0];
  assign hist_wr.x_new = in_sample;
  assign hist_wr.y_new = y_filt;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out  <= active ? y_filt : in_sample;
      clipped     <= active && y_clip;
      channel_out <= in_ch;
    end
  end

  // A held result never gets overwritten by the next beat
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(clipped)))
    else $error("stalled result changed");

  // Input stalls only behind a full, stalled result register
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without back-pressure");

  // Inactive channels pass the sample through unclipped
  assert property (@(posedge clk) disable iff (rst)
    (advance && !active) |=> (sample_out == $past(in_sample) && !clipped))
    else $error("inactive channel not passed through");

  // A clipped result sits on one of the rails
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN))
    else $error("clipped result not at a rail");

endmodule
